// ===== rtl/i2c_mbe_pkg.sv =====
// shared types and constants of the i2c master bit engine
`timescale 1ns / 1ps

package i2c_mbe_pkg;

   localparam int UNIT_W = 16;
   localparam logic [UNIT_W-1:0] UNIT_TICKS_RESET = 16'd48;
   localparam int TDATA_W = 16;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_STOP  = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   // one request: a clock tick of the timebase with its command offer
   typedef struct packed {
      logic       sda_in;
      logic       send_ack;
      logic [7:0] tx_byte;
      cmd_type    cmd;
      logic       cmd_valid;
   } req_item_type;

   // bus levels and status after the tick
   typedef struct packed {
      logic       nack_seen;
      logic [7:0] rx_byte;
      logic       done_res;
      logic       ready_res;
      logic       sda_pull_low;
      logic       scl_out;
   } rsp_item_type;

   localparam int REQ_BITS = $bits(req_item_type);
   localparam int RSP_BITS = $bits(rsp_item_type);

endpackage

// ===== rtl/i2c_mbe_core.sv =====
// bus sequencer: phase state, timing counters and shift register, one tick per step
`timescale 1ns / 1ps

module i2c_mbe_core
   import i2c_mbe_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  req_item_type      item,
   input  logic [UNIT_W-1:0] unit_ticks,
   output rsp_item_type      result
);

   typedef enum logic [3:0] {
      PH_IDLE, PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B,
      PH_WR_LEAD, PH_WR_SETUP, PH_WR_HIGH, PH_WR_LOW, PH_WR_TAIL,
      PH_ACK_REL, PH_ACK_HIGH, PH_RD_LOW, PH_RD_HIGH, PH_RA_LOW, PH_RA_HIGH
   } phase_type;

   function automatic logic [3:0] phase_units(input phase_type p);
      logic [3:0] u;
      case (p)
         PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B, PH_WR_HIGH: u = 4'd4;
         PH_ACK_REL, PH_ACK_HIGH:                         u = 4'd10;
         default:                                         u = 4'd2;
      endcase
      return u;
   endfunction

   phase_type         phase_ff, phase_in;
   logic [3:0]        bit_count_ff, bit_count_in;
   logic [3:0]        unit_count_ff, unit_count_in;
   logic [UNIT_W-1:0] tick_count_ff, tick_count_in;
   logic [7:0]        shift_ff, shift_in;
   logic [7:0]        rx_hold_ff, rx_hold_in;
   logic              ack_choice_ff, ack_choice_in;
   logic              nack_flag_ff, nack_flag_in;
   logic              scl_level_ff, scl_level_in;
   logic              sda_level_ff, sda_level_in;

   logic              done;
   logic              enter_en;
   phase_type         enter_ph;
   logic [UNIT_W-1:0] unit;
   logic [UNIT_W:0]   tick_inc;
   logic [3:0]        unit_inc;

   always_comb begin
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      unit_count_in = unit_count_ff;
      tick_count_in = tick_count_ff;
      shift_in      = shift_ff;
      rx_hold_in    = rx_hold_ff;
      ack_choice_in = ack_choice_ff;
      nack_flag_in  = nack_flag_ff;
      scl_level_in  = scl_level_ff;
      sda_level_in  = sda_level_ff;
      done          = 1'b0;
      enter_en      = 1'b0;
      enter_ph      = PH_IDLE;
      // a zero unit length behaves as one tick
      unit     = (unit_ticks == '0) ? {{(UNIT_W-1){1'b0}}, 1'b1} : unit_ticks;
      tick_inc = {1'b0, tick_count_ff} + {{UNIT_W{1'b0}}, 1'b1};
      unit_inc = unit_count_ff + 4'd1;

      if (phase_ff == PH_IDLE) begin
         if (item.cmd_valid) begin
            bit_count_in  = 4'd0;
            ack_choice_in = item.send_ack;
            shift_in      = (item.cmd == CMD_WRITE) ? item.tx_byte : 8'h00;
            enter_en      = 1'b1;
            unique case (item.cmd)
               CMD_START: enter_ph = PH_ST_A;
               CMD_STOP:  enter_ph = PH_SP_A;
               CMD_WRITE: enter_ph = PH_WR_LEAD;
               CMD_READ:  enter_ph = PH_RD_LOW;
            endcase
         end
      end else if (tick_inc >= {1'b0, unit}) begin
         tick_count_in = '0;
         unit_count_in = unit_inc;
         if (unit_inc >= phase_units(phase_ff)) begin
            unique case (phase_ff)
               PH_ST_A: begin
                  enter_en = 1'b1;
                  enter_ph = PH_ST_B;
               end
               PH_ST_B: begin
                  scl_level_in = 1'b0;
                  phase_in     = PH_IDLE;
                  unit_count_in = 4'd0;
                  done         = 1'b1;
               end
               PH_SP_A: begin
                  enter_en = 1'b1;
                  enter_ph = PH_SP_B;
               end
               PH_SP_B: begin
                  phase_in      = PH_IDLE;
                  unit_count_in = 4'd0;
                  done          = 1'b1;
               end
               PH_WR_LEAD: begin
                  enter_en = 1'b1;
                  enter_ph = PH_WR_SETUP;
               end
               PH_WR_SETUP: begin
                  enter_en = 1'b1;
                  enter_ph = PH_WR_HIGH;
               end
               PH_WR_HIGH: begin
                  enter_en = 1'b1;
                  enter_ph = PH_WR_LOW;
               end
               PH_WR_LOW: begin
                  bit_count_in = bit_count_ff + 4'd1;
                  enter_en     = 1'b1;
                  enter_ph     = (bit_count_in < 4'd8) ? PH_WR_SETUP : PH_WR_TAIL;
               end
               PH_WR_TAIL: begin
                  enter_en = 1'b1;
                  enter_ph = PH_ACK_REL;
               end
               PH_ACK_REL: begin
                  enter_en = 1'b1;
                  enter_ph = PH_ACK_HIGH;
               end
               PH_ACK_HIGH: begin
                  nack_flag_in  = item.sda_in;
                  scl_level_in  = 1'b0;
                  phase_in      = PH_IDLE;
                  unit_count_in = 4'd0;
                  done          = 1'b1;
               end
               PH_RD_LOW: begin
                  enter_en = 1'b1;
                  enter_ph = PH_RD_HIGH;
               end
               PH_RD_HIGH: begin
                  shift_in     = {shift_ff[6:0], item.sda_in};
                  bit_count_in = bit_count_ff + 4'd1;
                  enter_en     = 1'b1;
                  if (bit_count_in < 4'd8) begin
                     enter_ph = PH_RD_LOW;
                  end else begin
                     rx_hold_in = shift_in;
                     enter_ph   = PH_RA_LOW;
                  end
               end
               PH_RA_LOW: begin
                  enter_en = 1'b1;
                  enter_ph = PH_RA_HIGH;
               end
               PH_RA_HIGH: begin
                  scl_level_in  = 1'b0;
                  phase_in      = PH_IDLE;
                  unit_count_in = 4'd0;
                  done          = 1'b1;
               end
               PH_IDLE: begin
                  phase_in      = PH_IDLE;
                  unit_count_in = 4'd0;
               end
            endcase
         end
      end else begin
         tick_count_in = tick_inc[UNIT_W-1:0];
      end

      // entry actions of the new phase
      if (enter_en) begin
         phase_in      = enter_ph;
         unit_count_in = 4'd0;
         tick_count_in = '0;
         case (enter_ph)
            PH_ST_A: begin
               scl_level_in = 1'b1;
               sda_level_in = 1'b1;
            end
            PH_ST_B: begin
               scl_level_in = 1'b1;
               sda_level_in = 1'b0;
            end
            PH_SP_A: begin
               scl_level_in = 1'b0;
               sda_level_in = 1'b0;
            end
            PH_SP_B: begin
               scl_level_in = 1'b1;
               sda_level_in = 1'b1;
            end
            // lead-in, low and tail leave sda where it was
            PH_WR_LEAD, PH_WR_LOW, PH_WR_TAIL: scl_level_in = 1'b0;
            PH_WR_SETUP: begin
               scl_level_in = 1'b0;
               sda_level_in = shift_in[7];
               shift_in     = {shift_in[6:0], 1'b0};
            end
            PH_WR_HIGH, PH_RA_HIGH: scl_level_in = 1'b1;
            PH_ACK_REL, PH_RD_LOW: begin
               scl_level_in = 1'b0;
               sda_level_in = 1'b1;
            end
            PH_ACK_HIGH, PH_RD_HIGH: begin
               scl_level_in = 1'b1;
               sda_level_in = 1'b1;
            end
            PH_RA_LOW: begin
               scl_level_in = 1'b0;
               sda_level_in = ~ack_choice_in;
            end
            default: begin
               scl_level_in = scl_level_in;
            end
         endcase
      end
   end

   always_comb begin
      result.scl_out      = scl_level_in;
      result.sda_pull_low = ~sda_level_in;
      result.ready_res    = (phase_in == PH_IDLE);
      result.done_res     = done;
      result.rx_byte      = rx_hold_in;
      result.nack_seen    = nack_flag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_count_ff  <= 4'd0;
         unit_count_ff <= 4'd0;
         tick_count_ff <= '0;
         shift_ff      <= 8'h00;
         rx_hold_ff    <= 8'h00;
         ack_choice_ff <= 1'b0;
         nack_flag_ff  <= 1'b0;
         scl_level_ff  <= 1'b1;
         sda_level_ff  <= 1'b1;
      end else if (step) begin
         phase_ff      <= phase_in;
         bit_count_ff  <= bit_count_in;
         unit_count_ff <= unit_count_in;
         tick_count_ff <= tick_count_in;
         shift_ff      <= shift_in;
         rx_hold_ff    <= rx_hold_in;
         ack_choice_ff <= ack_choice_in;
         nack_flag_ff  <= nack_flag_in;
         scl_level_ff  <= scl_level_in;
         sda_level_ff  <= sda_level_in;
      end
   end

endmodule

// ===== rtl/i2c_master_bit_engine.sv =====
// top level of the i2c master bit engine: request register, sequencer, response register
//
//   channel | direction | payload
//   req     | in        | one timebase tick with command offer and sampled sda
//   rsp     | out       | scl level, sda pull, ready, done, received byte, nack flag
//   csr     | in        | unit_ticks, clock ticks per timing unit
//
// one request per clock cycle is accepted while no response is stalled; it passes
// through the request register, then the sequencer step into the response register.
// a stalled response holds the sequencer; the request register takes one more
// request meanwhile only if it was empty, after which req_tready drops.
// reset clears the bus to released (scl high, sda free) and unit_ticks to 48.
// csr writes are always taken and act on the next step.
`timescale 1ns / 1ps

module i2c_master_bit_engine
   import i2c_mbe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   // cmd_valid, cmd[1:0], tx_byte[7:0], send_ack, sda_in; zero fill above
   input  logic [TDATA_W-1:0] req_tdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // scl_out, sda_pull_low, ready_res, done_res, rx_byte[7:0], nack_seen; zero fill
   output logic [TDATA_W-1:0] rsp_tdata,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [UNIT_W-1:0]  csr_data
);

   logic              in_valid_ff, in_valid_in;
   req_item_type      in_item_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_item_ff;
   logic [UNIT_W-1:0] unit_ticks_ff;
   logic              advance;
   logic              req_fire;
   rsp_item_type      core_result;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   i2c_mbe_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .item       (in_item_ff),
      .unit_ticks (unit_ticks_ff),
      .result     (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         unit_ticks_ff <= UNIT_TICKS_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unit_ticks_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= req_item_type'(req_tdata[REQ_BITS-1:0]);
      end
      if (advance) begin
         rsp_item_ff <= core_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(TDATA_W-RSP_BITS){1'b0}}, rsp_item_ff};

endmodule

// ===== rtl/i2c_mbe_checker.sv =====
// port-level checks of the i2c master bit engine, bound to the top level
`timescale 1ns / 1ps

module i2c_mbe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // after reset no response is pending
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // with the response side empty a request is always taken
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with no response pending");

   // a completing command always leaves the engine idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |-> rsp_tdata[2])
      else $error("done without ready");

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

endmodule

bind i2c_master_bit_engine i2c_mbe_checker u_checker (.*);
